// File: design/xoshiro256ss_random_source_unit_assert.svh
// Assertion macros for the xoshiro256** random source unit.
`ifndef XOSHIRO256SS_RANDOM_SOURCE_UNIT_ASSERT_SVH
`define XOSHIRO256SS_RANDOM_SOURCE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define XRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define XRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/xrs_pkg.sv
// Shared types, constants and helpers for the xoshiro256** random source.
`timescale 1ns / 1ps

package xrs_pkg;

    localparam int WORD_W  = 64;
    localparam int HALF_W  = 32;
    localparam int BOUND_W = 31;
    localparam int FRAC_SHIFT = 40;

    localparam logic [WORD_W-1:0] SEED_RESET   = 64'd1;
    localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94d049bb133111eb;

    typedef enum logic [1:0] {
        ACT_RAW    = 2'd0,
        ACT_FRAC   = 2'd1,
        ACT_BOUND  = 2'd2,
        ACT_RESEED = 2'd3
    } t_action;

    typedef struct packed {
        logic                start;
        t_action             action;
        logic [BOUND_W-1:0]  bound;
        logic [WORD_W-1:0]   seed;
        logic                ack;
    } t_core_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [WORD_W-1:0]  value;
    } t_core_rsp;

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v,
                                                  input int unsigned amt);
        return (v << amt) | (v >> (WORD_W - amt));
    endfunction

endpackage

// File: design/xrs_mul.sv
// Shared 32x32 multiplier with a registered product.
`timescale 1ns / 1ps

module xrs_mul (
    input  logic                         i_clk,
    input  logic [xrs_pkg::HALF_W-1:0]   i_a,
    input  logic [xrs_pkg::HALF_W-1:0]   i_b,
    output logic [xrs_pkg::WORD_W-1:0]   o_prod
);
    import xrs_pkg::*;

    logic [WORD_W-1:0] r_prod;

    // register one partial product per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= WORD_W'(i_a) * WORD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// File: design/xrs_core.sv
// Sequencer, generator state and datapath around the shared multiplier.
`timescale 1ns / 1ps

module xrs_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  xrs_pkg::t_core_req i_req,
    output xrs_pkg::t_core_rsp o_rsp
);
    import xrs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCRAMBLE,
        S_BMUL,
        S_PREP1,
        S_MUL,
        S_PREP2,
        S_FIN,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [WORD_W-1:0]  r_s [4];
    logic [WORD_W-1:0]  r_acc;
    logic [WORD_W-1:0]  r_x;
    logic [WORD_W-1:0]  r_ctr;
    logic [1:0]         r_widx;
    logic [1:0]         r_mstep;
    logic               r_mpass;
    logic               r_user;
    t_action            r_action;
    logic [BOUND_W-1:0] r_bound;

    logic [HALF_W-1:0]  w_mul_a;
    logic [HALF_W-1:0]  w_mul_b;
    logic [WORD_W-1:0]  w_prod;
    logic [WORD_W-1:0]  w_k;
    logic [WORD_W-1:0]  w_ctr_next;
    logic [WORD_W-1:0]  w_scr;
    logic [WORD_W-1:0]  w_s3x;

    xrs_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_k        = r_mpass ? MIX_MUL_B : MIX_MUL_A;
    assign w_ctr_next = r_ctr + GOLDEN_GAMMA;
    assign w_scr      = rotl64(r_acc, 7);
    assign w_s3x      = r_s[3] ^ r_s[1];

    // pick multiplier operands for the current step
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_MUL: begin
                case (r_mstep)
                    2'd0: begin
                        w_mul_a = r_x[HALF_W-1:0];
                        w_mul_b = w_k[HALF_W-1:0];
                    end
                    2'd1: begin
                        w_mul_a = r_x[WORD_W-1:HALF_W];
                        w_mul_b = w_k[HALF_W-1:0];
                    end
                    2'd2: begin
                        w_mul_a = r_x[HALF_W-1:0];
                        w_mul_b = w_k[WORD_W-1:HALF_W];
                    end
                    default: ;
                endcase
            end
            S_BMUL: begin
                case (r_mstep)
                    2'd0: begin
                        w_mul_a = r_acc[WORD_W-1:HALF_W];
                        w_mul_b = {1'b0, r_bound};
                    end
                    2'd1: begin
                        w_mul_a = r_acc[HALF_W-1:0];
                        w_mul_b = {1'b0, r_bound};
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // sequence draws and reseeds; seed from the reset seed after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_PREP1;
            r_ctr   <= SEED_RESET;
            r_widx  <= '0;
            r_mstep <= '0;
            r_mpass <= 1'b0;
            r_user  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_action <= i_req.action;
                        r_bound  <= i_req.bound;
                        if (i_req.action == ACT_RESEED) begin
                            r_ctr   <= i_req.seed;
                            r_widx  <= '0;
                            r_user  <= 1'b1;
                            r_state <= S_PREP1;
                        end else begin
                            // s1 * 5, then advance the state
                            r_acc   <= r_s[1] + (r_s[1] << 2);
                            r_s[0]  <= r_s[0] ^ r_s[3] ^ r_s[1];
                            r_s[1]  <= r_s[1] ^ r_s[2] ^ r_s[0];
                            r_s[2]  <= r_s[2] ^ r_s[0] ^ (r_s[1] << 17);
                            r_s[3]  <= rotl64(w_s3x, 45);
                            r_state <= S_SCRAMBLE;
                        end
                    end
                end
                S_SCRAMBLE: begin
                    // rotate by 7, times 9
                    r_acc   <= w_scr + (w_scr << 3);
                    r_mstep <= '0;
                    r_state <= (r_action == ACT_BOUND) ? S_BMUL : S_DONE;
                end
                S_BMUL: begin
                    r_mstep <= r_mstep + 2'd1;
                    if (r_mstep == 2'd1) begin
                        r_x <= w_prod;
                    end else if (r_mstep == 2'd2) begin
                        r_acc   <= (r_x + (w_prod >> HALF_W)) >> HALF_W;
                        r_state <= S_DONE;
                    end
                end
                S_PREP1: begin
                    r_ctr   <= w_ctr_next;
                    r_x     <= w_ctr_next ^ (w_ctr_next >> 30);
                    r_mstep <= '0;
                    r_mpass <= 1'b0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // low 64 bits of x * k from three partial products
                    r_mstep <= r_mstep + 2'd1;
                    case (r_mstep)
                        2'd1: r_acc <= w_prod;
                        2'd2: r_acc <= r_acc + {w_prod[HALF_W-1:0], {HALF_W{1'b0}}};
                        2'd3: begin
                            r_acc   <= r_acc + {w_prod[HALF_W-1:0], {HALF_W{1'b0}}};
                            r_state <= r_mpass ? S_FIN : S_PREP2;
                        end
                        default: ;
                    endcase
                end
                S_PREP2: begin
                    r_x     <= r_acc ^ (r_acc >> 27);
                    r_mstep <= '0;
                    r_mpass <= 1'b1;
                    r_state <= S_MUL;
                end
                S_FIN: begin
                    r_s[r_widx] <= r_acc ^ (r_acc >> 31);
                    r_widx      <= r_widx + 2'd1;
                    if (r_widx == 2'd3) begin
                        r_state <= r_user ? S_DONE : S_IDLE;
                    end else begin
                        r_state <= S_PREP1;
                    end
                end
                S_DONE: begin
                    // hold the result until the output register takes it
                    if (i_req.ack) begin
                        r_user  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // shape the result by action
    always_comb begin
        o_rsp.busy = (r_state != S_IDLE);
        o_rsp.done = (r_state == S_DONE);
        case (r_action)
            ACT_RAW:   o_rsp.value = r_acc;
            ACT_FRAC:  o_rsp.value = r_acc >> FRAC_SHIFT;
            ACT_BOUND: o_rsp.value = r_acc;
            default:   o_rsp.value = '0;
        endcase
    end

endmodule

// File: design/xoshiro256ss_random_source_unit.sv
// Top level of the xoshiro256** random source with SplitMix64 seeding.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------
//  request | in        | i_valid / o_stall  | i_action[1:0], i_bound[30:0]
//  result  | out       | o_valid / i_stall  | o_value[63:0]
//  seed    | in        | i_seed_value_we    | i_seed_value[63:0]
//
// Raw and fraction draws go from accept through the scramble step to the result;
// bounded draws add a multiply step, as the high product is built from two passes
// through the shared 32x32 multiplier. A reseed runs four SplitMix64 rounds (two
// 64-bit multiplies of three partial products each).
// After reset the same seeding pass runs from seed 1 with o_stall high.
// A result waiting behind i_stall keeps the core holding, so o_stall stays high.
`timescale 1ns / 1ps

module xoshiro256ss_random_source_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_action,
    input  logic [xrs_pkg::BOUND_W-1:0]  i_bound,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [xrs_pkg::WORD_W-1:0]   o_value,
    input  logic                         i_seed_value_we,
    input  logic [xrs_pkg::WORD_W-1:0]   i_seed_value
);
    import xrs_pkg::*;

    logic [WORD_W-1:0] r_seed;
    logic              r_ovalid;
    logic [WORD_W-1:0] r_value;
    logic              w_out_free;
    t_core_req         w_req;
    t_core_rsp         w_rsp;

    assign w_out_free = !r_ovalid || !i_stall;

    assign w_req.start  = i_valid && !w_rsp.busy;
    assign w_req.action = t_action'(i_action);
    assign w_req.bound  = i_bound;
    assign w_req.seed   = r_seed;
    assign w_req.ack    = w_out_free;

    xrs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // hold the seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (i_seed_value_we) begin
            r_seed <= i_seed_value;
        end
    end

    // load the output register when free, drop the item once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_rsp.done && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rsp.done && w_out_free) begin
            r_value <= w_rsp.value;
        end
    end

    assign o_stall = w_rsp.busy;
    assign o_valid = r_ovalid;
    assign o_value = r_value;

    `include "xoshiro256ss_random_source_unit_assert.svh"

    `XRS_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "core idle after accept")
    `XRS_ASSERT_NEXT(a_done_holds, w_rsp.done && !w_out_free, w_rsp.done, "result lost")
    `XRS_ASSERT_NOW(a_valid_from_core, $rose(r_ovalid), $past(w_rsp.done), "result invented")

endmodule
